>>> sv/sps_pkg.sv
`default_nettype none

package sps_pkg;

    // item modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // run sub modes
    localparam logic [1:0] SUB_NORMAL = 2'd0;
    localparam logic [1:0] SUB_COMP   = 2'd1;
    localparam logic [1:0] SUB_WAIT   = 2'd2;

    // stop reasons
    localparam logic [2:0] STOP_RUNNING = 3'd0;
    localparam logic [2:0] STOP_END     = 3'd1;
    localparam logic [2:0] STOP_READY   = 3'd2;
    localparam logic [2:0] STOP_BLOCKED = 3'd3;
    localparam logic [2:0] STOP_UNKNOWN = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_LOSS_LIMIT   = 2'd0;
    localparam logic [1:0] REG_ENCODER_EN   = 2'd1;
    localparam logic [1:0] REG_READY_EN     = 2'd2;
    localparam logic [1:0] REG_READY_LEVEL  = 2'd3;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 31;
    localparam logic [30:0] LOSS_LIMIT_RESET = 31'd1000;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         seg_index;
        logic [15:0]        seg_steps;
        logic [15:0]        seg_period;
        logic [8:0]         run_length;
        logic [1:0]         run_sub_mode;
        logic               run_positive;
        logic signed [31:0] start_coordinate;
        logic               ready_level;
        logic signed [31:0] encoder_coordinate;
    } cmd_t;

    typedef struct packed {
        logic               pulse_valid;
        logic [15:0]        pulse_period;
        logic               stopped;
        logic [2:0]         stop_reason;
        logic signed [31:0] motor_coordinate;
    } res_t;

    typedef struct packed {
        logic [30:0] loss_limit;
        logic        encoder_en;
        logic        ready_en;
        logic        ready_level;
    } cfg_t;

endpackage

`default_nettype wire

>>> sv/sps_stream_if.sv
`default_nettype none

interface sps_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/sps_seg_store.sv
`default_nettype none

module sps_seg_store #(
    parameter int TABLE_DEPTH = 256,
    parameter int COUNT_WIDTH = 16,
    parameter int IW          = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   rd_en,
    input  wire logic [IW-1:0]          rd_addr,
    input  wire logic                   cnt_we,
    input  wire logic                   per_we,
    input  wire logic [IW-1:0]          wr_addr,
    input  wire logic [COUNT_WIDTH-1:0] wr_cnt,
    input  wire logic [15:0]            wr_per,
    output logic      [COUNT_WIDTH-1:0] rd_cnt,
    output logic      [15:0]            rd_per
);

    logic [COUNT_WIDTH-1:0] cnt_mem [TABLE_DEPTH];
    logic [15:0]            per_mem [TABLE_DEPTH];

    logic [COUNT_WIDTH-1:0] cnt_q_reg;
    logic [15:0]            per_q_reg;
    logic [COUNT_WIDTH-1:0] cnt_byp_reg;
    logic [15:0]            per_byp_reg;
    logic                   cnt_hit_reg;
    logic                   per_hit_reg;

    logic same_addr;
    assign same_addr = (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
        if (per_we)
        begin
            per_mem[wr_addr] <= wr_per;
        end
        if (rd_en)
        begin
            cnt_q_reg   <= cnt_mem[rd_addr];
            per_q_reg   <= per_mem[rd_addr];
            cnt_byp_reg <= wr_cnt;
            per_byp_reg <= wr_per;
        end
    end

    // a read that meets a write to the same entry takes the new data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_hit_reg <= 1'b0;
            per_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            cnt_hit_reg <= cnt_we && same_addr;
            per_hit_reg <= per_we && same_addr;
        end
    end

    assign rd_cnt = cnt_hit_reg ? cnt_byp_reg : cnt_q_reg;
    assign rd_per = per_hit_reg ? per_byp_reg : per_q_reg;

endmodule

`default_nettype wire

>>> sv/sps_seq_core.sv
`default_nettype none

module sps_seq_core #(
    parameter int TABLE_DEPTH = 256,
    parameter int COUNT_WIDTH = 16,
    parameter int IW          = 8,
    parameter int CW          = 9
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire sps_pkg::cfg_t          cfg,
    input  wire sps_pkg::cmd_t          item,
    input  wire logic                   commit,
    input  wire logic [COUNT_WIDTH-1:0] rd_cnt,
    input  wire logic [15:0]            rd_per,
    output logic      [IW-1:0]          rd_addr,
    output logic                        cnt_we,
    output logic                        per_we,
    output logic      [IW-1:0]          wr_addr,
    output logic      [COUNT_WIDTH-1:0] wr_cnt,
    output logic      [15:0]            wr_per,
    output sps_pkg::res_t               res
);

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [CW-1:0] ptr_reg,   ptr_next;
    logic [CW-1:0] total_reg, total_next;
    logic [1:0]    sub_reg,   sub_next;
    logic          dir_reg,   dir_next;
    logic          stop_reg,  stop_next;
    logic [2:0]    code_reg,  code_next;
    logic [31:0]   coord_reg, coord_next;

    logic                   pulse;
    logic [15:0]            period;
    logic                   cnt_wr;
    logic                   per_wr;
    logic                   load_ok;
    logic                   ready_fault;
    logic                   gap_fault;
    logic signed [32:0]     gap;
    logic signed [32:0]     lim;
    logic [COUNT_WIDTH-1:0] cnt_dec;
    logic [CW-1:0]          len;
    logic                   past_end;
    logic [31:0]            coord_fwd;
    logic [31:0]            coord_back;

    assign load_ok     = (32'(item.seg_index) < 32'(TABLE_DEPTH));
    assign ready_fault = cfg.ready_en && (item.ready_level != cfg.ready_level);
    assign gap         = $signed({coord_reg[31], coord_reg})
                       - $signed({item.encoder_coordinate[31], item.encoder_coordinate});
    assign lim         = $signed({2'b00, cfg.loss_limit});
    // exact gap, checked on both sides instead of taking its magnitude
    assign gap_fault   = cfg.encoder_en && ((gap > lim) || (gap < -lim));
    assign cnt_dec     = rd_cnt - COUNT_WIDTH'(1);
    assign len         = (CW'(item.run_length) > DEPTH_C) ? DEPTH_C : CW'(item.run_length);
    assign past_end    = (ptr_reg >= DEPTH_C);
    assign coord_fwd   = coord_reg + (dir_reg ? 32'd1 : 32'hFFFF_FFFF);
    assign coord_back  = coord_reg + (dir_reg ? 32'hFFFF_FFFF : 32'd1);

    always_comb
    begin
        ptr_next   = ptr_reg;
        total_next = total_reg;
        sub_next   = sub_reg;
        dir_next   = dir_reg;
        stop_next  = stop_reg;
        code_next  = code_reg;
        coord_next = coord_reg;
        pulse      = 1'b0;
        period     = '0;
        cnt_wr     = 1'b0;
        per_wr     = 1'b0;
        wr_addr    = IW'(ptr_reg);
        wr_cnt     = cnt_dec;
        case (item.mode)
            sps_pkg::MODE_LOAD:
            begin
                if (load_ok)
                begin
                    cnt_wr  = 1'b1;
                    per_wr  = 1'b1;
                    wr_addr = IW'(item.seg_index);
                    wr_cnt  = COUNT_WIDTH'(item.seg_steps);
                end
            end
            sps_pkg::MODE_START:
            begin
                ptr_next   = '0;
                total_next = len;
                sub_next   = item.run_sub_mode;
                dir_next   = item.run_positive;
                coord_next = item.start_coordinate;
                stop_next  = 1'b0;
                code_next  = sps_pkg::STOP_RUNNING;
            end
            sps_pkg::MODE_TICK:
            begin
                if (!stop_reg)
                begin
                    if (gap_fault)
                    begin
                        stop_next = 1'b1;
                        code_next = sps_pkg::STOP_BLOCKED;
                    end
                    else if (ready_fault)
                    begin
                        stop_next = 1'b1;
                        code_next = sps_pkg::STOP_READY;
                    end
                    else
                    begin
                        case (sub_reg)
                            sps_pkg::SUB_NORMAL:
                            begin
                                if (ptr_reg >= total_reg || past_end || rd_cnt == '0)
                                begin
                                    stop_next = 1'b1;
                                    code_next = sps_pkg::STOP_END;
                                end
                                else
                                begin
                                    pulse      = 1'b1;
                                    period     = rd_per;
                                    cnt_wr     = 1'b1;
                                    coord_next = coord_fwd;
                                    if (cnt_dec == '0)
                                    begin
                                        ptr_next = ptr_reg + CW'(1);
                                    end
                                end
                            end
                            sps_pkg::SUB_COMP:
                            begin
                                pulse      = 1'b1;
                                period     = past_end ? 16'd0 : rd_per;
                                coord_next = coord_back;
                            end
                            sps_pkg::SUB_WAIT:
                            begin
                                pulse      = 1'b1;
                                period     = past_end ? 16'd0 : rd_per;
                                coord_next = coord_fwd;
                            end
                            default:
                            begin
                                stop_next = 1'b1;
                                code_next = sps_pkg::STOP_UNKNOWN;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign wr_per = item.seg_period;
    assign cnt_we = commit && cnt_wr;
    assign per_we = commit && per_wr;

    // next read goes where the pointer will be once this request retires
    assign rd_addr = commit ? IW'(ptr_next) : IW'(ptr_reg);

    assign res.pulse_valid      = pulse;
    assign res.pulse_period     = period;
    assign res.stopped          = stop_next;
    assign res.stop_reason      = code_next;
    assign res.motor_coordinate = coord_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            total_reg <= '0;
            sub_reg   <= sps_pkg::SUB_NORMAL;
            dir_reg   <= 1'b1;
            stop_reg  <= 1'b1;
            code_reg  <= sps_pkg::STOP_END;
            coord_reg <= '0;
        end
        else if (commit)
        begin
            ptr_reg   <= ptr_next;
            total_reg <= total_next;
            sub_reg   <= sub_next;
            dir_reg   <= dir_next;
            stop_reg  <= stop_next;
            code_reg  <= code_next;
            coord_reg <= coord_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/stepper_segment_pulse_sequencer_top.sv
`default_nettype none

// Channel   Port                  Direction  Payload
// cmd       cmd (sink)            in         sps_pkg::cmd_t
// result    result (source)       out        sps_pkg::res_t
// config    cfg_we/index/data     in         31-bit write, no read-back
//
// A request is read from the segment table at the accepting edge and retires
// into the output register when the output is free. One request is accepted
// per cycle unless the result stalls; the read address is forwarded from the
// retiring request's next pointer and a same-entry write bypasses the read.
// Reset clears control and run state; the segment table is not cleared.
// A stalled result holds the retiring stage, which in turn holds cmd.ready.
module stepper_segment_pulse_sequencer_top #(
    parameter int TABLE_DEPTH = 256,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    sps_stream_if.sink                                cmd,
    sps_stream_if.source                              result,
    input  wire logic                                 cfg_we,
    input  wire logic [sps_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [sps_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (PW > 9) ? PW : 9;

    sps_pkg::cfg_t cfg_reg;
    sps_pkg::cmd_t item_reg;
    sps_pkg::res_t out_reg;
    sps_pkg::res_t res;
    logic          stage_valid_reg;
    logic          out_valid_reg;

    logic                   out_free;
    logic                   commit;
    logic                   accept;
    logic [IW-1:0]          rd_addr;
    logic                   cnt_we;
    logic                   per_we;
    logic [IW-1:0]          wr_addr;
    logic [COUNT_WIDTH-1:0] wr_cnt;
    logic [15:0]            wr_per;
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic [15:0]            rd_per;

    assign out_free  = !out_valid_reg || result.ready;
    assign commit    = stage_valid_reg && out_free;
    assign cmd.ready = !stage_valid_reg || out_free;
    assign accept    = cmd.valid && cmd.ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loss_limit  <= sps_pkg::LOSS_LIMIT_RESET;
            cfg_reg.encoder_en  <= 1'b0;
            cfg_reg.ready_en    <= 1'b0;
            cfg_reg.ready_level <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sps_pkg::REG_LOSS_LIMIT:  cfg_reg.loss_limit  <= cfg_data;
                sps_pkg::REG_ENCODER_EN:  cfg_reg.encoder_en  <= cfg_data[0];
                sps_pkg::REG_READY_EN:    cfg_reg.ready_en    <= cfg_data[0];
                sps_pkg::REG_READY_LEVEL: cfg_reg.ready_level <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd.data;
        end
        if (commit)
        begin
            out_reg <= res;
        end
    end

    sps_seg_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .IW          (IW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .cnt_we  (cnt_we),
        .per_we  (per_we),
        .wr_addr (wr_addr),
        .wr_cnt  (wr_cnt),
        .wr_per  (wr_per),
        .rd_cnt  (rd_cnt),
        .rd_per  (rd_per)
    );

    sps_seq_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .IW          (IW),
        .CW          (CW)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .commit  (commit),
        .rd_cnt  (rd_cnt),
        .rd_per  (rd_per),
        .rd_addr (rd_addr),
        .cnt_we  (cnt_we),
        .per_we  (per_we),
        .wr_addr (wr_addr),
        .wr_cnt  (wr_cnt),
        .wr_per  (wr_per),
        .res     (res)
    );

endmodule

`default_nettype wire
